// ===== rtl/core/mexp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types of the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int WORD_BITS = 32;
  localparam int EXT_W     = WORD_BITS + 2;
  localparam int CNT_W     = $clog2(WORD_BITS);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_EXPONENT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_EXPONENT = 2'd2;

  // Command to the modular multiplier: result = a * b mod n, with a < n.
  typedef struct packed {
    logic                 start;
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0] n;
  } mm_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage : mexp_pkg
`default_nettype wire

// ===== rtl/core/mexp_modmul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial interleaved modular multiplier. Scans b from its top bit, one
// bit per cycle: r = (2r + b_bit * a) mod n, which stays below 3n.
// ----------------------------------------------------------------------------
module mexp_modmul
  import mexp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mm_cmd_t              cmd,
  output mm_stat_t                  stat,
  output logic [WORD_BITS-1:0]      result
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     count;
  logic [WORD_BITS-1:0] r;
  logic [WORD_BITS-1:0] r_next;
  logic [WORD_BITS-1:0] a;
  logic [WORD_BITS-1:0] b;
  logic [EXT_W-1:0]     n1;
  logic [EXT_W-1:0]     n2;
  logic [EXT_W-1:0]     t;
  logic [EXT_W-1:0]     sub;

  always_comb begin
    t = {1'b0, r, 1'b0} + (b[WORD_BITS-1] ? EXT_W'(a) : '0);
    // Since r < n and a < n, t < 3n: at most 2n has to come off.
    if (t >= n2) begin
      sub = n2;
    end else if (t >= n1) begin
      sub = n1;
    end else begin
      sub = '0;
    end
    r_next = WORD_BITS'(t - sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r  <= '0;
      a  <= cmd.a;
      b  <= cmd.b;
      n1 <= EXT_W'(cmd.n);
      n2 <= EXT_W'({cmd.n, 1'b0});
    end else if (busy) begin
      r <= r_next;
      b <= b << 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = r;

endmodule : mexp_modmul
`default_nettype wire

// ===== rtl/core/modular_exponentiation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply on one shared bit-serial modular
// multiplier, with the base first reduced modulo the modulus.
// ----------------------------------------------------------------------------
// Work: the base reduction, then for each exponent bit up to its highest set bit a
// squaring on the shared multiplier, preceded by a multiply when the bit is set.
// A modulus of 0 or 1 gives 0 without any multiplication.
// One item at a time; the next item is taken while a result waits.
// Reset (synchronous) sets modulus and both exponents to 1 and idles the block.
module modular_exponentiation
  import mexp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic                 kind,
  input  wire logic [31:0]          message,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic [31:0]               value
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CHECK,
    S_MUL,
    S_SQR,
    S_DONE
  } state_t;

  state_t               state;
  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] pub_exp;
  logic [WORD_BITS-1:0] dec_exp;
  logic [WORD_BITS-1:0] expo;
  logic [WORD_BITS-1:0] base;
  logic [WORD_BITS-1:0] acc;
  mm_cmd_t              cmd;
  mm_stat_t             mm_stat;
  logic [WORD_BITS-1:0] mm_result;
  logic                 accept;
  logic                 out_free;
  logic                 start_next;

  mexp_modmul u_modmul (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (mm_stat),
    .result (mm_result)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // A multiplication starts for the base reduction, for every exponent bit
  // examined, and for the squaring that follows each multiply.
  always_comb begin
    unique case (state)
      S_IDLE:  start_next = accept && (modulus > WORD_BITS'(1));
      S_CHECK: start_next = (expo != '0);
      S_MUL:   start_next = mm_stat.done;
      default: start_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WORD_BITS'(1);
      pub_exp <= WORD_BITS'(1);
      dec_exp <= WORD_BITS'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODULUS:          modulus <= cfg_data[WORD_BITS-1:0];
        REG_PUBLIC_EXPONENT:  pub_exp <= cfg_data[WORD_BITS-1:0];
        REG_PRIVATE_EXPONENT: dec_exp <= cfg_data[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      cmd.start <= 1'b0;
    end else begin
      cmd.start <= start_next;
      rsp_valid <= ((state == S_DONE) && out_free) || (rsp_valid && rsp_stall);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            expo  <= kind ? dec_exp : pub_exp;
            cmd.n <= modulus;
            if (modulus <= WORD_BITS'(1)) begin
              acc   <= '0;
              state <= S_DONE;
            end else begin
              // Base reduction: 1 * message mod n.
              acc       <= WORD_BITS'(1);
              cmd.a     <= WORD_BITS'(1);
              cmd.b     <= message[WORD_BITS-1:0];
              state     <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (mm_stat.done) begin
            base  <= mm_result;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (expo == '0) begin
            state <= S_DONE;
          end else if (expo[0]) begin
            cmd.a     <= acc;
            cmd.b     <= base;
            state     <= S_MUL;
          end else begin
            cmd.a     <= base;
            cmd.b     <= base;
            state     <= S_SQR;
          end
        end
        S_MUL: begin
          if (mm_stat.done) begin
            acc       <= mm_result;
            cmd.a     <= base;
            cmd.b     <= base;
            state     <= S_SQR;
          end
        end
        S_SQR: begin
          if (mm_stat.done) begin
            base  <= mm_result;
            expo  <= expo >> 1;
            state <= S_CHECK;
          end
        end
        S_DONE: begin
          if (out_free) begin
            value     <= 32'(acc);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The multiplier is never left running once the block reports idle.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mm_stat.busy)
    else $error("multiplier busy while idle");

  // A finished multiplication is only seen in a state that waits for it.
  assert property (@(posedge clk) disable iff (rst)
    mm_stat.done |-> (state == S_REDUCE || state == S_MUL || state == S_SQR))
    else $error("multiplier finished outside a waiting state");

  // An accepted item always starts work.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item did not start");

  // A delivered value is fully reduced.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((value < 32'(modulus)) || (value == '0)))
    else $error("result not reduced modulo the modulus");

endmodule : modular_exponentiation
`default_nettype wire

// ===== tb/tb_modular_exponentiation.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Self-checking bench for the modular exponentiation block. A short table of
// hand-picked messages and keys comes first, then random messages under random
// keys. Each result is checked against the table or a square-and-multiply
// predictor, with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
  import mexp_pkg::*;

  // Index 3 is not a register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int DIR_ROWS     = 24;
  localparam int KEY_PHASES   = 9;
  localparam int PHASE_ITEMS  = 30;
  localparam int HOLD_CYCLES  = 6000;
  localparam int STALL_LIMIT  = 40000;
  localparam int TAIL_CYCLES  = 2400;
  localparam int IDLE_PCT     = 35;

  typedef struct packed {
    logic [31:0] modulus;
    logic [31:0] public_exp;
    logic [31:0] private_exp;
    logic        kind;
    logic [31:0] message;
    logic        typed;
    logic [31:0] result;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 req_valid;
  logic                 req_stall;
  logic                 kind;
  logic [31:0]          message;
  logic                 rsp_valid;
  logic                 rsp_stall;
  logic [31:0]          value;

  logic [31:0] cur_modulus;
  logic [31:0] cur_public_exp;
  logic [31:0] cur_private_exp;
  logic [31:0] expected_values[$];
  int          error_count = 0;
  int          req_idle_pct = IDLE_PCT;
  int          rsp_idle_pct = IDLE_PCT;
  bit          hold_request = 1'b0;
  int          idle_cycles = 0;
  logic        rsp_taken = 1'b0;
  logic [31:0] rsp_seen;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // Reset key: modulus one gives zero.
    '{32'd1, 32'd1, 32'd1, 1'b0, 32'h0000_1234, 1'b1, 32'd0},
    '{32'd1, 32'd1, 32'd1, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'd0},
    // Modulus zero also gives zero.
    '{32'd0, 32'd7, 32'd9, 1'b0, 32'd5, 1'b1, 32'd0},
    '{32'd0, 32'd7, 32'd9, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'd0},
    // Exponent zero gives one, even for a zero message.
    '{32'd13, 32'd0, 32'd0, 1'b0, 32'd5, 1'b1, 32'd1},
    '{32'd13, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1, 32'd1},
    '{32'd13, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'd1},
    '{32'd2, 32'd5, 32'd1, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'd1},
    '{32'd2, 32'd5, 32'd1, 1'b0, 32'd0, 1'b1, 32'd0},
    '{32'd2, 32'd5, 32'd1, 1'b1, 32'd3, 1'b1, 32'd1},
    // Largest modulus and exponent; a message equal to the modulus reduces to 0.
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'd1, 1'b1, 32'd1},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'd0, 1'b1, 32'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'hFFFF_FFFE, 1'b0, 32'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'h8000_0001, 1'b0, 32'd0},
    // Textbook key pair: encrypt and decrypt round trip.
    '{32'd3233, 32'd17, 32'd2753, 1'b0, 32'd65, 1'b1, 32'd2790},
    '{32'd3233, 32'd17, 32'd2753, 1'b1, 32'd2790, 1'b1, 32'd65},
    '{32'd3233, 32'd17, 32'd2753, 1'b0, 32'd3298, 1'b1, 32'd2790},
    '{32'hFFFF_FFFB, 32'h0001_0001, 32'hFFFF_FFFF, 1'b0, 32'hDEAD_BEEF, 1'b0, 32'd0},
    '{32'hFFFF_FFFB, 32'h0001_0001, 32'hFFFF_FFFF, 1'b1, 32'hDEAD_BEEF, 1'b0, 32'd0},
    '{32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'd3, 1'b0, 32'd0},
    '{32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'd7, 1'b0, 32'd0},
    '{32'd1, 32'd1, 32'd1, 1'b0, 32'd42, 1'b1, 32'd0}
  };

  modular_exponentiation i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .kind      (kind),
    .message   (message),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .value     (value)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Right-to-left square-and-multiply; all products fit in 64 bits.
  function automatic logic [31:0] mod_power(input logic [31:0] base,
                                            input logic [31:0] expo,
                                            input logic [31:0] n);
    logic [63:0] acc;
    logic [63:0] sq;
    if (n <= 32'd1) return 32'd0;
    acc = 64'd1;
    sq  = {32'd0, base} % {32'd0, n};
    for (int i = 0; i < 32; i++) begin
      if (expo[i]) acc = (acc * sq) % {32'd0, n};
      sq = (sq * sq) % {32'd0, n};
    end
    return acc[31:0];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_MODULUS:          cur_modulus = data;
      REG_PUBLIC_EXPONENT:  cur_public_exp = data;
      REG_PRIVATE_EXPONENT: cur_private_exp = data;
      default: ;
    endcase
  endtask

  task automatic load_key(input logic [31:0] m, input logic [31:0] pe,
                          input logic [31:0] pv);
    write_reg(REG_MODULUS, m);
    write_reg(REG_SPARE, $urandom());
    write_reg(REG_PUBLIC_EXPONENT, pe);
    write_reg(REG_PRIVATE_EXPONENT, pv);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Stops offering items and waits until every result is back, so the
  // block is idle before the key changes.
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
  endtask

  task automatic offer_message(input logic k, input logic [31:0] msg,
                               input logic [31:0] result);
    @(negedge clk);
    while ($urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    kind      <= k;
    message   <= msg;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_values.push_back(result);
  endtask

  // Output side: random stall, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
    end
  end

  // Capture at the rising edge, compare at the falling edge.
  always @(posedge clk) begin
    rsp_taken <= !rst && rsp_valid && !rsp_stall;
    rsp_seen  <= value;
  end

  always @(negedge clk) begin
    logic [31:0] want;
    if (rsp_taken) begin
      if (expected_values.size() == 0) begin
        $error("value: no result expected, got %h", rsp_seen);
        error_count++;
      end else begin
        want = expected_values.pop_front();
        if (rsp_seen !== want) begin
          $error("value: expected %h, got %h", want, rsp_seen);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t    row;
    logic [31:0] m;
    logic [31:0] pe;
    logic [31:0] pv;
    logic [31:0] msg;
    logic        k;

    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = REG_MODULUS;
    cfg_data        = 32'd0;
    req_valid       = 1'b0;
    kind            = 1'b0;
    message         = 32'd0;
    cur_modulus     = 32'd1;
    cur_public_exp  = 32'd1;
    cur_private_exp = 32'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = directed_rows[i];
      if (row.modulus != cur_modulus || row.public_exp != cur_public_exp ||
          row.private_exp != cur_private_exp) begin
        drain();
        load_key(row.modulus, row.public_exp, row.private_exp);
      end
      offer_message(row.kind, row.message, row.typed ? row.result :
                    mod_power(row.message, row.kind ? cur_private_exp : cur_public_exp,
                              cur_modulus));
    end

    for (int p = 0; p < KEY_PHASES; p++) begin
      case (p)
        0: begin
          m = '1; pe = '1; pv = '1;
        end
        1: begin
          m = $urandom_range(300, 2); pe = $urandom_range(31); pv = $urandom_range(31);
        end
        2: begin
          m = {1'b1, 31'($urandom())}; pe = 32'd0; pv = $urandom();
        end
        KEY_PHASES - 1: begin
          m = $urandom_range(16, 2); pe = '1; pv = 32'd0;
        end
        default: begin
          m = $urandom(); pe = $urandom(); pv = $urandom();
        end
      endcase
      drain();
      load_key(m, pe, pv);
      req_idle_pct = (p == 3) ? 0 : IDLE_PCT;
      rsp_idle_pct = (p == 3) ? 0 : IDLE_PCT;
      // Hold the output long enough that the block fills and stalls its input.
      if (p == 5) hold_request = 1'b1;
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        k = $urandom_range(1);
        case ($urandom_range(15))
          0:       msg = 32'd0;
          1:       msg = '1;
          2:       msg = cur_modulus;
          3:       msg = cur_modulus - 32'd1;
          4:       msg = cur_modulus + 32'd1;
          default: msg = $urandom();
        endcase
        offer_message(k, msg, mod_power(msg, k ? cur_private_exp : cur_public_exp,
                                         cur_modulus));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mexp_pkg.sv
rtl/core/mexp_modmul.sv
rtl/core/modular_exponentiation.sv
tb/tb_modular_exponentiation.sv
